// ----- rtl/c3smc_pkg.sv -----
// Package for the shadow mask closing unit: payload structs, register indexes,
// reset values and small helper functions.
// No dependencies.
package c3smc_pkg;

    localparam int ROW_W      = 13;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Q16    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LIMIT   = 2'd3;

    // Register reset values.
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [15:0]      RATIO_Q16_RST    = 16'd27708;
    localparam logic [8:0]       BLUE_LIMIT_RST   = 9'd110;

    // Frame dimension limits.
    localparam logic [DIM_W-1:0] DIM_MIN = 13'd3;
    localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

    // Item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in_item;

    typedef struct packed {
        logic shadow;
        logic frame_end;
    } t_out_item;

    // Saturates a frame dimension into [DIM_MIN, cap].
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        r = v;
        if (r < DIM_MIN) begin
            r = DIM_MIN;
        end
        if (r > cap) begin
            r = cap;
        end
        return r;
    endfunction

    // Which of the rows row-2, row-1 and row lie inside a frame of h rows.
    // Bit 2 is the oldest row, bit 0 the newest.
    function automatic logic [2:0] row_valid(input logic [ROW_W-1:0] row,
                                             input logic [DIM_W-1:0] h);
        logic vt;
        logic vm;
        logic vb;
        vb = row < h;
        vm = (row >= ROW_W'(1)) && ((row - ROW_W'(1)) < h);
        vt = (row >= ROW_W'(2)) && ((row - ROW_W'(2)) < h);
        return {vt, vm, vb};
    endfunction

endpackage

// ----- rtl/c3_shadow_mask_close_unit.sv -----
// Shadow mask with a 3x3 morphological closing over a raster pixel stream.
// Depends on c3smc_pkg (payload structs, register indexes, helper functions).
//
// The unit takes one pixel transfer per clock while the result side does not stall.
// Each pixel is marked shadow when blue*65536 > ratio_q16*max(red, green) and
// blue < blue_limit; the mask then gets a dilation and an erosion, each over the
// 3x3 window of in-frame neighbours. The two line memories (mask and dilated
// mask, two bits per column) each do one read and one write per clock, which is
// what sets the rate: one item per cycle while nothing stalls; an item passes stage 1
// and stage 2 into the result register. The result for frame position p leaves with
// the input transfer numbered p + 2*W + 2 within the frame, so a frame needs its
// W*H pixels followed by 2*W + 2 drain transfers (op = 1), or pixel transfers,
// whose colors are then dropped. Drain transfers arriving outside that drain
// window are taken and discarded. Width and height are sampled at the first
// pixel of a frame and clamped to [3, 4096], the width also to MAX_WIDTH;
// ratio_q16 and blue_limit apply immediately. The line memories need no clearing
// after reset: entries that were never written only feed rows outside the frame,
// which are masked. A waiting result does not block the pipeline behind it until
// the two internal stages are also full.
module c3_shadow_mask_close_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [c3smc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [c3smc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  c3smc_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output c3smc_pkg::t_out_item                 o_out_item
);
    import c3smc_pkg::*;

    // Line memory depth: the widest row that can be configured.
    localparam int DEPTH = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] W_CAP = DIM_W'(DEPTH);
    localparam logic [DIM_W-1:0] W_RST = clamp_dim(FRAME_WIDTH_RST, W_CAP);
    localparam logic [AW-1:0] W_LAST_RST = AW'(W_RST - DIM_W'(1));
    localparam logic [DIM_W-1:0] H_RST = clamp_dim(FRAME_HEIGHT_RST, DIM_MAX);

    // Stage 1: the mask line memory read is in flight; the mask bit is resolved here.
    typedef struct packed {
        logic [AW-1:0] col;      // column of the input position
        logic [23:0]   prod;     // ratio_q16 * max(red, green)
        logic [7:0]    blue;
        logic [2:0]    mrows;    // in-frame rows of the incoming mask column
        logic          dact;     // a dilation position is due
        logic [AW-1:0] dcol;
        logic          dleft;    // dilation position sits on the first column
        logic          dright;   // dilation position sits on the last column
        logic [2:0]    drows;    // in-frame rows of the incoming dilated column
        logic          ero;      // an erosion result is due
        logic          eleft;
        logic          eright;
        logic          last;
    } t_s1;

    // Stage 2: the dilated line memory read is in flight; erosion is resolved here.
    typedef struct packed {
        logic          dact;
        logic [AW-1:0] dcol;
        logic          dil;
        logic [2:0]    drows;
        logic          ero;
        logic          eleft;
        logic          eright;
        logic          last;
    } t_s2;

    // Configuration registers.
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [15:0]      r_ratio_q16;
    logic [8:0]       r_blue_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_ratio_q16    <= RATIO_Q16_RST;
            r_blue_limit   <= BLUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_RATIO_Q16:    r_ratio_q16    <= i_cfg_data;
                CFG_BLUE_LIMIT:   r_blue_limit   <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Scan positions: input, dilation (W+1 behind) and erosion/output (2W+2 behind).
    logic [AW-1:0]    r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [AW-1:0]    r_d_col,   n_d_col;
    logic [ROW_W-1:0] r_d_row,   n_d_row;
    logic [AW-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [AW-1:0]    r_w_last;
    logic [DIM_W-1:0] r_act_h;

    logic             r_s1_v;
    t_s1              r_s1;
    t_s1              n_s1;
    logic             r_s2_v;
    t_s2              r_s2;
    t_s2              n_s2;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             out_free;
    logic             adv1;
    logic             adv2;
    logic             s1_free;
    logic             s2_free;
    logic             out_load;

    // Flow control. Each stage moves when the one ahead of it is empty or moving;
    // items that produce no result never wait for the output register.
    assign out_free = !r_out_valid || i_out_ready;
    assign adv2     = r_s2_v && (!r_s2.ero || out_free);
    assign s2_free  = !r_s2_v || adv2;
    assign adv1     = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || adv1;
    assign out_load = adv2 && r_s2.ero;
    assign o_in_ready = s1_free;

    // Input stage: frame bookkeeping and the color product.
    logic             frame_start;
    logic [DIM_W-1:0] w_cfg;
    logic [DIM_W-1:0] h_cfg;
    logic [AW-1:0]    w_last;
    logic [DIM_W-1:0] h_cur;
    logic             pix_pos;
    logic             drop;
    logic             in_xfer;
    logic             take;
    logic             dil_act;
    logic             ero_ok;
    logic             last;
    logic [7:0]       max_rg;

    assign frame_start = (r_in_row == '0) && (r_in_col == '0);
    assign w_cfg   = clamp_dim(r_frame_width, W_CAP);
    assign h_cfg   = clamp_dim(r_frame_height, DIM_MAX);
    assign w_last  = frame_start ? AW'(w_cfg - DIM_W'(1)) : r_w_last;
    assign h_cur   = frame_start ? h_cfg : r_act_h;
    assign pix_pos = r_in_row < h_cur;
    // A drain transfer before the frame has started or before all its pixels
    // arrived has no effect at all.
    assign drop    = (i_in_item.op == OP_DRAIN) && (frame_start || pix_pos);
    assign in_xfer = i_in_valid && o_in_ready;
    assign take    = in_xfer && !drop;
    assign dil_act = (r_in_row >= ROW_W'(2)) ||
                     ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign ero_ok  = dil_act && ((r_d_row >= ROW_W'(2)) ||
                     ((r_d_row == ROW_W'(1)) && (r_d_col != '0)));
    assign last    = ero_ok && (r_out_row == (h_cur - DIM_W'(1))) && (r_out_col == w_last);
    assign max_rg  = (i_in_item.red > i_in_item.green) ? i_in_item.red : i_in_item.green;

    always_comb begin
        n_s1.col    = r_in_col;
        n_s1.prod   = 24'(r_ratio_q16) * 24'(max_rg);
        n_s1.blue   = i_in_item.blue;
        n_s1.mrows  = row_valid(r_in_row, h_cur);
        n_s1.dact   = dil_act;
        n_s1.dcol   = r_d_col;
        n_s1.dleft  = r_d_col == '0;
        n_s1.dright = r_d_col == w_last;
        n_s1.drows  = row_valid(r_d_row, h_cur);
        n_s1.ero    = ero_ok;
        n_s1.eleft  = r_out_col == '0;
        n_s1.eright = r_out_col == w_last;
        n_s1.last   = last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_d_col   = r_d_col;
        n_d_row   = r_d_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (r_in_col == w_last) begin
            n_in_col = '0;
            n_in_row = r_in_row + ROW_W'(1);
        end else begin
            n_in_col = r_in_col + AW'(1);
        end
        if (dil_act) begin
            if (r_d_col == w_last) begin
                n_d_col = '0;
                n_d_row = r_d_row + ROW_W'(1);
            end else begin
                n_d_col = r_d_col + AW'(1);
            end
        end
        if (ero_ok) begin
            if (r_out_col == w_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + AW'(1);
            end
        end
        if (last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_d_col   = '0;
            n_d_row   = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_d_col   <= '0;
            r_d_row   <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_w_last  <= W_LAST_RST;
            r_act_h   <= H_RST;
        end else if (take) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_d_col   <= n_d_col;
            r_d_row   <= n_d_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (frame_start) begin
                r_w_last <= w_last;
                r_act_h  <= h_cfg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= n_s1;
        end
    end

    // Mask line memory: entry c holds the mask of the two previous rows at
    // column c, older row in bit 1. Read when an item enters stage 1, written
    // back with the row shifted when it leaves.
    logic [1:0] mask_mem [DEPTH];
    logic [1:0] r_mask_rd;
    logic       mask_we;
    logic [1:0] mask_wdata;
    logic       shadow_bit;
    logic [2:0] mask_col;
    logic [8:0] r_mask_win;
    logic [8:0] n_mask_win;
    logic       dil_val;

    // Only an item on an in-frame row carries a pixel.
    assign shadow_bit = r_s1.mrows[0] && ({r_s1.blue, 16'h0000} > r_s1.prod) &&
                        ({1'b0, r_s1.blue} < r_blue_limit);
    assign mask_we    = adv1;
    assign mask_wdata = {r_mask_rd[0], shadow_bit};
    assign mask_col   = {r_mask_rd[1] & r_s1.mrows[2], r_mask_rd[0] & r_s1.mrows[1],
                         shadow_bit};
    assign n_mask_win = {r_mask_win[5:0], mask_col};
    // Dilation: OR over the window, the outer columns only when in frame.
    assign dil_val = ((|n_mask_win[8:6]) && !r_s1.dleft) || (|n_mask_win[5:3]) ||
                     ((|n_mask_win[2:0]) && !r_s1.dright);

    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            mask_mem[r_s1.col] <= mask_wdata;
        end
        if (take) begin
            r_mask_rd <= mask_mem[r_in_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_win <= '0;
        end else if (adv1) begin
            r_mask_win <= n_mask_win;
        end
    end

    always_comb begin
        n_s2.dact   = r_s1.dact;
        n_s2.dcol   = r_s1.dcol;
        n_s2.dil    = r_s1.dact && dil_val;
        n_s2.drows  = r_s1.drows;
        n_s2.ero    = r_s1.ero;
        n_s2.eleft  = r_s1.eleft;
        n_s2.eright = r_s1.eright;
        n_s2.last   = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= adv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s2 <= n_s2;
        end
    end

    // Dilated line memory, same layout as the mask memory, one window step
    // per dilation position.
    logic [1:0] dil_mem [DEPTH];
    logic [1:0] r_dil_rd;
    logic       dil_re;
    logic       dil_we;
    logic [2:0] dil_col;
    logic [8:0] r_dil_win;
    logic [8:0] n_dil_win;
    logic       ero_val;

    assign dil_re  = adv1 && r_s1.dact;
    assign dil_we  = adv2 && r_s2.dact;
    // Rows outside the frame count as set, so they never clear the erosion.
    assign dil_col = {r_dil_rd[1] | !r_s2.drows[2], r_dil_rd[0] | !r_s2.drows[1],
                      r_s2.dil | !r_s2.drows[0]};
    assign n_dil_win = {r_dil_win[5:0], dil_col};
    assign ero_val = ((&n_dil_win[8:6]) || r_s2.eleft) && (&n_dil_win[5:3]) &&
                     ((&n_dil_win[2:0]) || r_s2.eright);

    always_ff @(posedge i_clk) begin
        if (dil_we) begin
            dil_mem[r_s2.dcol] <= {r_dil_rd[0], r_s2.dil};
        end
        if (dil_re) begin
            r_dil_rd <= dil_mem[r_s1.dcol];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dil_win <= '0;
        end else if (dil_we) begin
            r_dil_win <= n_dil_win;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.shadow    <= ero_val;
            r_out_item.frame_end <= r_s2.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // A line memory entry is never read in the cycle it is written back.
    a_mask_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mask_we && take) |-> (r_s1.col != r_in_col))
        else $error("mask line memory read and write hit the same column");

    a_dil_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dil_we && dil_re) |-> (r_s2.dcol != r_s1.dcol))
        else $error("dilated line memory read and write hit the same column");

    a_cols_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= r_w_last) && (r_d_col <= r_w_last) && (r_out_col <= r_w_last))
        else $error("scan column beyond the latched frame width");

    a_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_row <= r_d_row) && (r_d_row <= r_in_row))
        else $error("output or dilation position runs ahead of the input");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for c3_shadow_mask_close_unit: directed and random pixel frames
// checked against a predictor of the shadow threshold and the 3x3 closing.
// Depends on c3smc_pkg and the unit's RTL only.
module tb_top;
    import c3smc_pkg::*;

    localparam int TB_MAX_WIDTH  = 4096;
    localparam int DIM_LIMIT     = 4096;
    // Cycles allowed after the last result before touching the registers, so that
    // ignored drain transfers still in the pipeline have left it.
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 300;

    // Predictor of the closed shadow mask. It keeps its own copy of the registers,
    // the scan counters and the two row stores, and queues one expected result per
    // frame position as the matching input transfer is accepted.
    class shadow_closing_tracker;
        bit [12:0]   width_reg;
        bit [12:0]   height_reg;
        bit [15:0]   ratio_reg;
        bit [8:0]    blue_lim_reg;
        int unsigned in_row, in_col, out_row, out_col;
        int unsigned act_w, act_h;
        bit          mask_rows[0:3*TB_MAX_WIDTH-1];
        bit          dilated_rows[0:3*TB_MAX_WIDTH-1];
        t_out_item   pending_masks[$];
        int unsigned mismatches;

        function new();
            width_reg    = 13'd640;
            height_reg   = 13'd480;
            ratio_reg    = 16'd27708;
            blue_lim_reg = 9'd110;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            act_w = 640; act_h = 480;
            mismatches = 0;
        endfunction

        function int unsigned fit_dim(int unsigned v, int unsigned cap);
            int unsigned d;
            d = v;
            if (d < 3) d = 3;
            if (d > DIM_LIMIT) d = DIM_LIMIT;
            if (d > cap) d = cap;
            return d;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH: width_reg = data[12:0];
                CFG_FRAME_HEIGHT: height_reg = data[12:0];
                CFG_RATIO_Q16: ratio_reg = data[15:0];
                CFG_BLUE_LIMIT: blue_lim_reg = data[8:0];
                default: ;
            endcase
        endfunction

        function bit in_frame(int r, int c);
            return (r >= 0) && (c >= 0) && (r < int'(act_h)) && (c < int'(act_w));
        endfunction

        function bit neighbor_or(int r, int c);
            bit v;
            v = 1'b0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if (in_frame(r + dr, c + dc)) begin
                        v |= mask_rows[((r + dr) % 3) * TB_MAX_WIDTH + c + dc];
                    end
                end
            end
            return v;
        endfunction

        function bit neighbor_and(int r, int c);
            bit v;
            v = 1'b1;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if (in_frame(r + dr, c + dc)) begin
                        v &= dilated_rows[((r + dr) % 3) * TB_MAX_WIDTH + c + dc];
                    end
                end
            end
            return v;
        endfunction

        // Called for every accepted input transfer.
        function void accept_item(t_in_item it);
            int unsigned t, npix, lat, p, pr, pc, mx, b, g, r;
            bit          flag;
            bit          last;
            t_out_item   want;
            if (in_row == 0 && in_col == 0) begin
                // No frame running: a drain is dropped, a pixel latches the size.
                if (it.op == OP_DRAIN) return;
                act_w = fit_dim(32'(width_reg), TB_MAX_WIDTH);
                act_h = fit_dim(32'(height_reg), DIM_LIMIT);
            end
            t    = in_row * act_w + in_col;
            npix = act_w * act_h;
            lat  = act_w + 1;
            if (t < npix) begin
                // Drains before the last pixel are dropped without effect.
                if (it.op == OP_DRAIN) return;
                b = 32'(it.blue);
                g = 32'(it.green);
                r = 32'(it.red);
                mx = (r > g) ? r : g;
                flag = (b * 65536 > int'(ratio_reg) * mx) && (b < 32'(blue_lim_reg));
                mask_rows[(in_row % 3) * TB_MAX_WIDTH + in_col] = flag;
            end
            if (t >= lat && t - lat < npix) begin
                p  = t - lat;
                pr = p / act_w;
                pc = p % act_w;
                dilated_rows[(pr % 3) * TB_MAX_WIDTH + pc] = neighbor_or(pr, pc);
            end
            in_col++;
            if (in_col >= act_w) begin
                in_col = 0;
                in_row++;
            end
            if (t >= 2 * lat && t - 2 * lat < npix) begin
                last = (t - 2 * lat) == npix - 1;
                want.shadow    = neighbor_and(out_row, out_col);
                want.frame_end = last;
                pending_masks = {pending_masks, want};
                out_col++;
                if (out_col >= act_w) begin
                    out_col = 0;
                    out_row++;
                end
                if (last) begin
                    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
                end
            end
        endfunction

        // Called for every accepted result transfer.
        function void compare_mask(t_out_item got);
            t_out_item want;
            if (pending_masks.size() == 0) begin
                $error("result with nothing pending: shadow=%0d frame_end=%0d",
                       got.shadow, got.frame_end);
                mismatches++;
                return;
            end
            want = pending_masks.pop_front();
            if (got.shadow !== want.shadow) begin
                $error("shadow: expected %0d, actual %0d", want.shadow, got.shadow);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
                mismatches++;
            end
        endfunction
    endclass

    // Every input of the unit starts from a known value.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    shadow_closing_tracker tracker = new();

    // Idle knobs in percent: sender gaps per cycle and receiver stalls per cycle.
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned phase_items   = 0;

    c3_shadow_mask_close_unit #(
        .MAX_WIDTH (TB_MAX_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: the slowest correct run stays far below this.
    initial begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side. A transfer is taken at the edge where valid and ready are both high;
    // ready is then redrawn for the next cycle from the current stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.compare_mask(o_out_item);
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_in_item make_pixel(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r);
        t_in_item it;
        it.op    = OP_PIXEL;
        it.blue  = b;
        it.green = g;
        it.red   = r;
        return it;
    endfunction

    // Drain transfers carry random colors; the unit must ignore them.
    function automatic t_in_item make_drain();
        t_in_item it;
        it = make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        it.op = OP_DRAIN;
        return it;
    endfunction

    // A pixel drawn so that shadow and non-shadow both turn up often. Part of the
    // pixels sit near the ratio threshold, a few have zero red and green.
    function automatic t_in_item random_pixel(input int shade_pct);
        int unsigned b, top;
        if ($urandom_range(99) < 6) begin
            return make_pixel(8'($urandom_range(255)), 8'd0, 8'd0);
        end
        if ($urandom_range(99) < shade_pct) begin
            b   = $urandom_range(1, 140);
            top = (2 * b + 30 > 255) ? 255 : 2 * b + 30;
            return make_pixel(8'(b), 8'($urandom_range(top)), 8'($urandom_range(top)));
        end
        return make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
    endfunction

    // Offers one item and returns once it has been transferred. A gap, if drawn, drops
    // valid first; otherwise valid stays high straight into the next item.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.accept_item(it);
    endtask

    // Stops sending and waits until every predicted result has been transferred,
    // then lets the pipeline run empty of ignored drains.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_masks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Writes all four registers on consecutive edges; the unit must be idle.
    task automatic write_settings(input logic [15:0] w, input logic [15:0] h,
                                  input logic [15:0] ratio, input logic [15:0] lim);
        i_cfg_we <= 1'b1;
        cfg_beat(CFG_FRAME_WIDTH, w);
        cfg_beat(CFG_FRAME_HEIGHT, h);
        cfg_beat(CFG_RATIO_Q16, ratio);
        cfg_beat(CFG_BLUE_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    // One whole frame: its pixels, then the 2*W+2 flush transfers, with stray drains
    // that the unit ignores mixed in. With hold_mid set, the sender stops halfway
    // until every result due so far has come out.
    task automatic run_frame(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] ratio, input logic [15:0] lim,
                             input bit hold_mid);
        int unsigned fw, fh, npix, shade;
        settle();
        write_settings(w, h, ratio, lim);
        fw    = tracker.fit_dim(32'(w[12:0]), TB_MAX_WIDTH);
        fh    = tracker.fit_dim(32'(h[12:0]), DIM_LIMIT);
        npix  = fw * fh;
        shade = $urandom_range(10, 90);
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(make_drain());
        end
        for (int unsigned i = 0; i < npix; i++) begin
            if (i != 0 && $urandom_range(24) == 0) begin
                send_item(make_drain());
            end
            send_item(random_pixel(shade));
            phase_items++;
            if (hold_mid && i == npix / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (tracker.pending_masks.size() != 0) @(posedge i_clk);
            end
        end
        // During the flush a pixel acts as a drain and its colors are dropped.
        for (int unsigned i = 0; i < 2 * fw + 2; i++) begin
            if ($urandom_range(4) == 0) begin
                send_item(random_pixel(50));
            end else begin
                send_item(make_drain());
            end
            phase_items++;
        end
    endtask

    // Frame size for random frames: mostly tiny, sometimes wider, now and then below
    // the minimum so that the clamp is exercised.
    function automatic logic [15:0] random_dim(input int unsigned typical);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return 16'($urandom_range(2));
        if (pick < 18) return 16'($urandom_range(3, 40));
        return 16'($urandom_range(3, typical));
    endfunction

    function automatic logic [15:0] random_ratio();
        if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
        return 16'($urandom_range(12000, 60000));
    endfunction

    initial begin
        int unsigned guard;

        // Synchronous reset, held at the start and never asserted again.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frame, W=H=3 through the clamp from 0 and 2, default thresholds.
        write_settings(16'd0, 16'd2, 16'd27708, 16'd110);
        send_item(make_drain());                          // no frame running: ignored
        send_item(make_pixel(8'd255, 8'd255, 8'd255));    // all channels at the top
        send_item(make_pixel(8'd0, 8'd0, 8'd0));          // zero max and zero blue
        send_item(make_pixel(8'd1, 8'd0, 8'd0));          // zero max, blue above zero
        send_item(make_drain());                          // frame incomplete: ignored
        send_item(make_pixel(8'd109, 8'd0, 8'd255));      // red is the max
        send_item(make_pixel(8'd110, 8'd0, 8'd0));        // blue at its limit
        send_item(make_pixel(8'd109, 8'd255, 8'd0));      // green is the max
        send_item(make_pixel(8'd100, 8'd236, 8'd17));     // just above the ratio
        send_item(make_pixel(8'd100, 8'd237, 8'd0));      // just below the ratio
        send_item(make_pixel(8'd50, 8'd120, 8'd120));     // red and green equal
        send_item(make_pixel(8'd77, 8'd33, 8'd201));      // flush: acts as a drain
        repeat (7) send_item(make_drain());
        send_item(make_drain());                          // after frame end: ignored

        // Four idle phases: none, sender gaps, receiver stalls, both. Each starts with
        // a frame at extreme thresholds or an odd shape, then runs random frames.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            phase_items = 0;
            case (phase)
                0: run_frame(16'd6, 16'd5, 16'd0, 16'hFFFF, 1'b0);
                1: run_frame(16'd7, 16'd6, 16'hFFFF, 16'd256, 1'b1);
                2: run_frame(16'd5, 16'd4, random_ratio(), 16'd0, 1'b0);
                default: run_frame(16'd20, 16'd3, 16'd27708, 16'd110, 1'b0);
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                run_frame(random_dim(12), random_dim(10), random_ratio(),
                          16'($urandom_range(60, 300)), 1'b0);
            end
        end

        // Wait for the last results, with a bound, then for the pipeline to run dry.
        i_in_valid <= 1'b0;
        guard = 0;
        while (tracker.pending_masks.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (tracker.pending_masks.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_masks.size());
            tracker.mismatches++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/c3smc_pkg.sv
rtl/c3_shadow_mask_close_unit.sv
tb/tb_top.sv
